/* rtl/dgfd_pkg.sv */
// Shared types and constants for the debounced gravity face detector.
package dgfd_pkg;

	// Raw accelerometer sample width
	localparam int SAMPLE_BITS = 16;
	localparam int TIME_BITS   = 32;
	localparam int CFG_BITS    = 16;
	// Magnitude width: one bit more so full-scale negative does not wrap
	localparam int MAG_W       = SAMPLE_BITS + 1;
	// Signed strength width: covers a negated full-scale sample plus the margin
	localparam int STR_W = ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 2;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 16;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [TIME_BITS-1:0]          stamp_t;
	typedef logic [CFG_BITS-1:0]           cfg_word_t;
	typedef logic signed [STR_W-1:0]       strength_t;

	// Configuration register indexes
	typedef enum logic {
		REG_LEAD_MARGIN  = 1'b0,
		REG_CONFIRM_TIME = 1'b1
	} reg_index_t;

	// Face encoding
	typedef enum logic [2:0] {
		FACE_PX = 3'd0,
		FACE_NX = 3'd1,
		FACE_PY = 3'd2,
		FACE_NY = 3'd3,
		FACE_PZ = 3'd4,
		FACE_NZ = 3'd5
	} face_t;

	typedef struct packed {
		sample_t x;
		sample_t y;
		sample_t z;
		stamp_t  now;
	} sample_item_t;

	typedef struct packed {
		face_t  confirmed;
		face_t  candidate;
		stamp_t start;
	} face_state_t;

	typedef struct packed {
		logic [1:0] quadrant;
		logic       side;
		face_t      pending;
		face_t      target;
	} face_result_t;

	typedef struct packed {
		cfg_word_t lead_margin;
		cfg_word_t confirm_time;
	} face_cfg_t;

endpackage

/* rtl/dgfd_classify.sv */
// Dominant face search, margin test and confirm timer for one sample.
module dgfd_classify (
	input  dgfd_pkg::sample_item_t item,
	input  dgfd_pkg::face_state_t  cur,
	input  dgfd_pkg::face_cfg_t    cfg,
	output dgfd_pkg::face_state_t  nxt,
	output dgfd_pkg::face_result_t res
);
	import dgfd_pkg::*;

	logic [MAG_W-1:0] mag_x, mag_y, mag_z;
	face_t            raw_face;
	strength_t        str_raw, str_cur, str_limit;
	stamp_t           elapsed;

	// Sign-extend a sample into the strength width
	function automatic strength_t widen(input sample_t v);
		widen = strength_t'({{(STR_W-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v});
	endfunction

	// Signed strength of a face for this sample
	function automatic strength_t face_strength(input face_t f, input sample_t x,
			input sample_t y, input sample_t z);
		case (f)
			FACE_PX: face_strength = widen(x);
			FACE_NX: face_strength = -widen(x);
			FACE_PY: face_strength = widen(y);
			FACE_NY: face_strength = -widen(y);
			FACE_PZ: face_strength = widen(z);
			FACE_NZ: face_strength = -widen(z);
			default: face_strength = '0;
		endcase
	endfunction

	// Magnitude, one bit wider so full-scale negative does not wrap
	function automatic logic [MAG_W-1:0] magnitude(input sample_t v);
		logic signed [MAG_W-1:0] e;
		e = {v[SAMPLE_BITS-1], v};
		magnitude = (e < 0) ? MAG_W'(-e) : MAG_W'(e);
	endfunction

	assign mag_x = magnitude(item.x);
	assign mag_y = magnitude(item.y);
	assign mag_z = magnitude(item.z);

	// Dominant axis; any tie falls to Z, zero picks the minus face
	always_comb begin
		if (mag_x > mag_y && mag_x > mag_z) begin
			raw_face = (item.x > 0) ? FACE_PX : FACE_NX;
		end else if (mag_y > mag_x && mag_y > mag_z) begin
			raw_face = (item.y > 0) ? FACE_PY : FACE_NY;
		end else begin
			raw_face = (item.z > 0) ? FACE_PZ : FACE_NZ;
		end
	end

	assign str_raw   = face_strength(raw_face, item.x, item.y, item.z);
	assign str_cur   = face_strength(cur.confirmed, item.x, item.y, item.z);
	assign str_limit = str_cur + strength_t'({{(STR_W-CFG_BITS){1'b0}}, cfg.lead_margin});
	assign elapsed   = item.now - cur.start;

	// Candidate tracking and confirmation
	always_comb begin
		nxt = cur;
		if (raw_face == cur.confirmed) begin
			nxt.candidate = cur.confirmed;
		end else if (str_raw > str_limit) begin
			if (raw_face != cur.candidate) begin
				nxt.candidate = raw_face;
				nxt.start     = item.now;
			end else if (elapsed >= stamp_t'(cfg.confirm_time)) begin
				nxt.confirmed = cur.candidate;
			end
		end else begin
			nxt.candidate = cur.confirmed;
		end
	end

	// Result fields from the updated state
	always_comb begin
		res.target  = nxt.confirmed;
		res.pending = nxt.candidate;
		res.side    = (nxt.confirmed <= FACE_NY);
		case (nxt.confirmed)
			FACE_PX: res.quadrant = 2'd0;
			FACE_PY: res.quadrant = 2'd1;
			FACE_NX: res.quadrant = 2'd2;
			FACE_NY: res.quadrant = 2'd3;
			default: res.quadrant = 2'd0;
		endcase
	end

endmodule

/* rtl/debounced_gravity_face_detector.sv */
// Top level: input register, face state, config registers and result register.
// A sample passes through the input register, then the result register, to m_tdata.
// Throughput: one sample per cycle unless m_tready holds a result; the face state loop has one register.
// With a result waiting downstream the input register takes one more sample, then stalls.
// Reset (arst_n low, asynchronous): both faces go to +Z, timer start to 0,
// lead margin to 4096, confirm_time to 500, and both stages empty.
module debounced_gravity_face_detector (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// s_tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32], now_ms [79:48]
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [dgfd_pkg::IN_DATA_W-1:0]         s_tdata,
	// m_tdata: target_face [2:0], pending_face [5:3], side_flag [6],
	//          side_quadrant [8:7], zero [15:9]
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [dgfd_pkg::OUT_DATA_W-1:0]        m_tdata,
	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [dgfd_pkg::CFG_BITS-1:0]          cfg_wdata
);
	import dgfd_pkg::*;

	sample_item_t item_s1;
	logic         valid_s1;
	face_state_t  state_q, state_nxt;
	face_cfg_t    cfg_q;
	face_result_t res_nxt, res_s2;
	logic         valid_s2;
	logic         advance;

	// Stage 1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead_margin  <= CFG_BITS'(4096);
			cfg_q.confirm_time <= CFG_BITS'(500);
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_LEAD_MARGIN:  cfg_q.lead_margin  <= cfg_wdata;
				REG_CONFIRM_TIME: cfg_q.confirm_time <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.x   <= sample_t'(s_tdata[15:0]);
			item_s1.y   <= sample_t'(s_tdata[31:16]);
			item_s1.z   <= sample_t'(s_tdata[47:32]);
			item_s1.now <= s_tdata[79:48];
		end
	end

	dgfd_classify u_classify (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Face state, updated once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.confirmed <= FACE_PZ;
			state_q.candidate <= FACE_PZ;
			state_q.start     <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.quadrant, res_s2.side, res_s2.pending, res_s2.target};

	// A new confirmed face must have been the pending one
	a_confirm_from_candidate: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(state_q.confirmed) |-> state_q.confirmed == $past(state_q.candidate))
		else $error("confirmed face changed to a face that was not pending");

	// State only moves when a sample is processed
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("face state changed without a sample");

	// Timer restarts only together with a new candidate
	a_start_with_candidate: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(state_q.start) |-> state_q.candidate != $past(state_q.candidate))
		else $error("timer restarted without a new candidate");

	// No new sample taken while both stages are full and blocked
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |-> !s_tready)
		else $error("input accepted while pipeline is stalled");

endmodule

/* bench/testbench.sv */
// Self-checking bench for the debounced gravity face detector: directed and random samples.
`timescale 1ns / 100ps

module testbench;
	import dgfd_pkg::*;

	// Tracks the face state from accepted samples and checks each result word
	class face_scoreboard;
		face_t        confirmed;
		face_t        candidate;
		stamp_t       started_ms;
		cfg_word_t    margin;
		cfg_word_t    hold_ms;
		face_result_t expected_faces[$];
		int           mismatches;

		function new();
			confirmed = FACE_PZ;
			candidate = FACE_PZ;
			started_ms = '0;
			margin = 16'd4096;
			hold_ms = 16'd500;
			mismatches = 0;
		endfunction

		function void set_reg(reg_index_t idx, cfg_word_t value);
			if (idx == REG_LEAD_MARGIN)
				margin = value;
			else
				hold_ms = value;
		endfunction

		// Largest magnitude wins strictly; any tie falls to Z, zero picks the minus face
		function face_t dominant_face(int x, int y, int z);
			int mx, my, mz;
			mx = (x < 0) ? -x : x;
			my = (y < 0) ? -y : y;
			mz = (z < 0) ? -z : z;
			if (mx > my && mx > mz)
				return (x > 0) ? FACE_PX : FACE_NX;
			if (my > mx && my > mz)
				return (y > 0) ? FACE_PY : FACE_NY;
			return (z > 0) ? FACE_PZ : FACE_NZ;
		endfunction

		function int axis_strength(face_t f, int x, int y, int z);
			case (f)
				FACE_PX: return x;
				FACE_NX: return -x;
				FACE_PY: return y;
				FACE_NY: return -y;
				FACE_PZ: return z;
				FACE_NZ: return -z;
				default: return 0;
			endcase
		endfunction

		// Advance the face state by one sample and queue the result it gives
		function void accept_sample(sample_item_t s);
			int           x, y, z;
			face_t        raw;
			face_result_t r;
			x = $signed(s.x);
			y = $signed(s.y);
			z = $signed(s.z);
			raw = dominant_face(x, y, z);
			if (raw == confirmed) begin
				candidate = confirmed;
			end else if (axis_strength(raw, x, y, z) >
					axis_strength(confirmed, x, y, z) + int'(margin)) begin
				if (raw != candidate) begin
					candidate = raw;
					started_ms = s.now;
				end else if (stamp_t'(s.now - started_ms) >= hold_ms) begin
					confirmed = candidate;
				end
			end else begin
				candidate = confirmed;
			end
			r.target = confirmed;
			r.pending = candidate;
			r.side = (confirmed == FACE_PX || confirmed == FACE_NX ||
				confirmed == FACE_PY || confirmed == FACE_NY);
			case (confirmed)
				FACE_PX: r.quadrant = 2'd0;
				FACE_PY: r.quadrant = 2'd1;
				FACE_NX: r.quadrant = 2'd2;
				FACE_NY: r.quadrant = 2'd3;
				default: r.quadrant = 2'd0;
			endcase
			expected_faces.push_back(r);
		endfunction

		// Compare one result word with the oldest expected faces
		function void check_result(logic [OUT_DATA_W-1:0] word);
			face_result_t got, want;
			logic [OUT_DATA_W-$bits(face_result_t)-1:0] pad;
			got = word[$bits(face_result_t)-1:0];
			pad = word[OUT_DATA_W-1:$bits(face_result_t)];
			if (expected_faces.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result %h with no sample outstanding", $realtime, word);
				return;
			end
			want = expected_faces.pop_front();
			if (got.target !== want.target || got.pending !== want.pending ||
					got.side !== want.side || got.quadrant !== want.quadrant ||
					pad !== '0) begin
				mismatches++;
				// Fields shown as target/pending/side/quadrant
				if (mismatches <= 10)
					$display("%0t: exp %0d/%0d/%0b/%0d got %0d/%0d/%0b/%0d pad %h",
						$realtime, want.target, want.pending, want.side, want.quadrant,
						got.target, got.pending, got.side, got.quadrant, pad);
			end
		endfunction
	endclass

	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 108;
	localparam int LONG_STALL   = 120;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we;
	reg_index_t            cfg_index;
	cfg_word_t             cfg_wdata;

	face_scoreboard tracker;
	stamp_t         ms_clock = '0;
	int             phase_items;
	int             burst_left = 0;
	int             no_gap_left = 0;
	bit             long_stall_req = 1'b0;

	debounced_gravity_face_detector DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Check every result taken by the receiver
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	// Receiver: switches between stall patterns, plus one long hold-off on request
	initial begin : ready_driver
		rx_mode_t mode;
		int       mode_left;
		int       tick;
		mode = RX_OPEN;
		mode_left = 0;
		tick = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_stall_req) begin
				m_tready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				long_stall_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(3, 0));
					mode_left = $urandom_range(200, 20);
				end
				mode_left--;
				tick++;
				case (mode)
					RX_OPEN:    m_tready <= 1'b1;
					RX_COIN:    m_tready <= 1'($urandom_range(1, 0));
					RX_SPARSE:  m_tready <= ($urandom_range(3, 0) == 0);
					RX_CADENCE: m_tready <= (tick % 5 != 0);
					default:    m_tready <= 1'b1;
				endcase
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("debounced_gravity_face_detector: mismatch");
		$finish;
	end

	function automatic sample_item_t sample_of(int x, int y, int z, stamp_t t);
		sample_item_t s;
		s.x = sample_t'(x);
		s.y = sample_t'(y);
		s.z = sample_t'(z);
		s.now = t;
		return s;
	endfunction

	function automatic sample_item_t noise_sample();
		return sample_of($urandom(), $urandom(), $urandom(), $urandom());
	endfunction

	// A sample that leans toward face f, other axes smaller with random signs
	function automatic sample_item_t face_sample(face_t f, stamp_t t);
		int mag, dom, a, b;
		mag = ($urandom_range(3, 0) == 0) ? $urandom_range(32767, 1) :
			$urandom_range(32767, 12000);
		if ((f == FACE_NX || f == FACE_NY || f == FACE_NZ) && $urandom_range(15, 0) == 0)
			mag = 32768;
		dom = (f == FACE_PX || f == FACE_PY || f == FACE_PZ) ? mag : -mag;
		a = $urandom_range(mag - 1, 0);
		b = $urandom_range(mag - 1, 0);
		if ($urandom_range(1, 0))
			a = -a;
		if ($urandom_range(1, 0))
			b = -b;
		case (f)
			FACE_PX, FACE_NX: return sample_of(dom, a, b, t);
			FACE_PY, FACE_NY: return sample_of(a, dom, b, t);
			default:          return sample_of(a, b, dom, t);
		endcase
	endfunction

	// Present one item and hold it until accepted; returns on a falling edge
	task automatic send_sample(input sample_item_t s);
		s_tdata <= {s.now, s.z, s.y, s.x};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.accept_sample(s);
		@(negedge clk);
	endtask

	task automatic idle(input int cycles);
		if (cycles > 0) begin
			s_tvalid <= 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	// Send with burst/gap pacing on the sender side
	task automatic offer(input sample_item_t s);
		send_sample(s);
		phase_items++;
		if (no_gap_left > 0) begin
			no_gap_left--;
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle($urandom_range(8, 1));
			burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20) :
				$urandom_range(12, 0);
		end
	endtask

	// Stop sending until every expected result is out, then let the pipe settle
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (tracker.expected_faces.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input cfg_word_t value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, value);
		@(negedge clk);
	endtask

	// A run of samples toward one face with a fixed time step, some noise mixed in
	task automatic run_face_run();
		face_t  f;
		int     len;
		stamp_t step;
		f = face_t'($urandom_range(5, 0));
		len = $urandom_range(12, 2);
		if ($urandom_range(7, 0) == 0)
			ms_clock = 32'hFFFF_FFFF - $urandom_range(3000, 0);
		case ($urandom_range(3, 0))
			0:       step = $urandom_range(40, 0);
			1:       step = tracker.hold_ms / 2 + $urandom_range(3, 0);
			2:       step = tracker.hold_ms;
			default: step = $urandom();
		endcase
		repeat (len) begin
			ms_clock += step;
			if ($urandom_range(9, 0) == 0)
				offer(noise_sample());
			else
				offer(face_sample(f, ms_clock));
		end
	endtask

	initial begin : stimulus
		cfg_word_t margin_plan[PHASES];
		cfg_word_t hold_plan[PHASES];
		int p;
		bit paused;
		margin_plan = '{16'd4096, 16'd0, 16'hFFFF, 16'd0, 16'd1000, 16'd0, 16'hFFFF};
		hold_plan = '{16'd500, 16'd0, 16'hFFFF, 16'd0, 16'd20, 16'hFFFF, 16'd0};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_LEAD_MARGIN;
		cfg_wdata = '0;
		tracker = new();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: zero sample, confirm timing, wrap, ties, margin
		offer(sample_of(0, 0, 0, 0));
		offer(sample_of(32767, 0, 0, 100));
		offer(sample_of(32767, -5, 7, 599));
		offer(sample_of(32767, 0, 0, 600));
		offer(sample_of(32767, 1, 1, 601));
		offer(sample_of(-32768, 0, 0, 1000));
		offer(sample_of(1000, 1000, 5, 1001));
		offer(sample_of(3, -32768, -2, 32'hFFFF_FF00));
		offer(sample_of(3, -32768, -2, 32'h0000_00F4));
		offer(sample_of(4100, -4000, 0, 32'h0000_0100));
		offer(sample_of(-32768, -32768, -32768, 32'hFFFF_FFFF));
		offer(sample_of(32767, 32767, 32767, 0));
		offer(sample_of(-1, 0, 0, 2));

		// Zero margin and zero confirm time: a new candidate still waits one sample
		wait_drain();
		write_reg(REG_LEAD_MARGIN, 16'd0);
		write_reg(REG_CONFIRM_TIME, 16'd0);
		offer(sample_of(0, 0, 32767, 5));
		offer(sample_of(0, 0, 32767, 5));
		offer(sample_of(0, 0, -32768, 7));

		// Largest margin and confirm time
		wait_drain();
		write_reg(REG_LEAD_MARGIN, 16'hFFFF);
		write_reg(REG_CONFIRM_TIME, 16'hFFFF);
		offer(sample_of(0, 0, -32768, 65541));
		offer(sample_of(0, 0, -32768, 65542));
		offer(sample_of(0, 0, -32767, 65543));
		offer(sample_of(0, 0, 32767, 70000));

		// Random phases, one register setting each
		margin_plan[3] = cfg_word_t'($urandom_range(16'hFFFF, 0));
		hold_plan[3] = cfg_word_t'($urandom_range(3000, 1));
		for (p = 0; p < PHASES; p++) begin
			wait_drain();
			write_reg(REG_LEAD_MARGIN, margin_plan[p]);
			write_reg(REG_CONFIRM_TIME, hold_plan[p]);
			phase_items = 0;
			paused = 1'b0;
			if (p == 3) begin
				long_stall_req = 1'b1;
				no_gap_left = 24;
			end
			while (phase_items < PHASE_ITEMS) begin
				if (!paused && phase_items >= PHASE_ITEMS / 2) begin
					wait_drain();
					paused = 1'b1;
				end
				if ($urandom_range(9, 0) < 8)
					run_face_run();
				else
					repeat ($urandom_range(4, 1)) offer(noise_sample());
			end
		end

		wait_drain();
		repeat (8) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.expected_faces.size() == 0)
			$display("debounced_gravity_face_detector: match");
		else
			$display("debounced_gravity_face_detector: mismatch");
		$finish;
	end

endmodule

/* debounced_gravity_face_detector.f */
rtl/dgfd_pkg.sv
rtl/dgfd_classify.sv
rtl/debounced_gravity_face_detector.sv
bench/testbench.sv
